// ===== hw/rtl/cffr_pkg.sv =====
// Types and constants shared by the chunked firmware fetch requester.
`timescale 1ns / 1ps
package cffr_pkg;

	localparam logic [15:0] CHUNK_LIMIT_RST = 16'd2000;

	localparam logic [2:0] OP_START       = 3'd0;
	localparam logic [2:0] OP_FIND_RSP    = 3'd1;
	localparam logic [2:0] OP_FETCH_RSP   = 3'd2;
	localparam logic [2:0] OP_RELEASE_RSP = 3'd3;

	localparam logic [1:0] KIND_FIND    = 2'd0;
	localparam logic [1:0] KIND_FETCH   = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;

	localparam logic [1:0] ERR_NONE        = 2'd0;
	localparam logic [1:0] ERR_REMOTE      = 2'd1;
	localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  remote_status;
		logic [7:0]  found_id;
		logic [30:0] found_size;
		logic [15:0] port;
	} item_t;

	typedef struct packed {
		logic        req_valid;
		logic [1:0]  req_kind;
		logic [30:0] req_offset;
		logic [15:0] req_size;
		logic [7:0]  req_id;
		logic [15:0] req_port;
		logic        done_res;
		logic [1:0]  error;
		logic [7:0]  error_code;
	} result_t;

endpackage

// ===== hw/rtl/cffr_stream_if.sv =====
// Valid/ready channel interface carrying one payload beat.
`timescale 1ns / 1ps
interface cffr_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cffr_engine.sv =====
// Download state registers and the combinational logic that turns one beat into a result.
`timescale 1ns / 1ps
module cffr_engine
	import cffr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] chunk_limit,
	input  logic        step,
	input  item_t       item,
	output result_t     res
);

	logic [7:0]  image_id_q;
	logic [30:0] image_size_q;
	logic [30:0] bytes_read_q;
	logic [15:0] pending_chunk_q;

	logic [30:0] read_sum;
	logic [30:0] base_read;
	logic [30:0] base_size;
	logic        more_left;
	logic [30:0] remaining;
	logic [15:0] chunk;
	logic        is_response_ok;

	assign read_sum  = bytes_read_q + {15'd0, pending_chunk_q};
	assign base_read = (item.op == OP_FIND_RSP) ? bytes_read_q : read_sum;
	assign base_size = (item.op == OP_FIND_RSP) ? item.found_size : image_size_q;
	assign more_left = base_size > base_read;
	assign remaining = more_left ? (base_size - base_read) : 31'd0;
	assign chunk     = (remaining < {15'd0, chunk_limit}) ? remaining[15:0] : chunk_limit;
	assign is_response_ok = (item.op != OP_START) && (item.remote_status == 8'd0);

	always_comb begin
		res = '0;
		if (item.op == OP_START) begin
			res.req_valid = 1'b1;
			res.req_kind  = KIND_FIND;
			res.req_port  = item.port;
		end else if (item.remote_status != 8'd0) begin
			res.error      = ERR_REMOTE;
			res.error_code = item.remote_status;
		end else begin
			unique case (item.op)
				OP_FIND_RSP: begin
					res.req_valid  = 1'b1;
					res.req_kind   = KIND_FETCH;
					res.req_offset = bytes_read_q;
					res.req_size   = chunk;
					res.req_id     = item.found_id;
					res.req_port   = item.port;
				end
				OP_FETCH_RSP: begin
					res.req_valid = 1'b1;
					res.req_id    = image_id_q;
					res.req_port  = item.port;
					if (more_left) begin
						res.req_kind   = KIND_FETCH;
						res.req_offset = read_sum;
						res.req_size   = chunk;
					end else begin
						res.req_kind = KIND_RELEASE;
					end
				end
				OP_RELEASE_RSP: begin
					res.done_res = 1'b1;
				end
				default: begin
					res.error = ERR_UNSUPPORTED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_id_q      <= '0;
			image_size_q    <= '0;
			bytes_read_q    <= '0;
			pending_chunk_q <= '0;
		end else if (step && is_response_ok) begin
			if (item.op == OP_FIND_RSP) begin
				image_id_q      <= item.found_id;
				image_size_q    <= item.found_size;
				pending_chunk_q <= chunk;
			end else if (item.op == OP_FETCH_RSP) begin
				if (read_sum == image_size_q) begin
					image_size_q    <= '0;
					bytes_read_q    <= '0;
					pending_chunk_q <= '0;
				end else if (more_left) begin
					bytes_read_q    <= read_sum;
					pending_chunk_q <= chunk;
				end else begin
					bytes_read_q <= read_sum;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/chunked_firmware_fetch_requester.sv =====
// Top level of the chunked firmware fetch requester.
// Each input beat is captured in an input register, processed combinationally
// against the download state, and its single result beat is then registered
// in an output register once that register is empty or being taken. One beat
// is accepted per cycle while the result side keeps taking beats; the rate is
// set by the state update in the engine, since each response depends on the
// counters left by the previous one. The chunk limit register resets to 2000
// bytes and must only be written while no beat is in flight.
`timescale 1ns / 1ps
module chunked_firmware_fetch_requester
	import cffr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [15:0]         wr_data,
	cffr_stream_if.sink         item,
	cffr_stream_if.source       result
);

	logic [15:0] chunk_limit_q;
	logic        item_valid_s1;
	item_t       item_s1;
	logic        res_valid_q;
	result_t     res_q;
	result_t     res_next;
	logic        advance;

	assign advance    = item_valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_limit_q <= CHUNK_LIMIT_RST;
		end else if (wr_en) begin
			chunk_limit_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			item_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	cffr_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.chunk_limit (chunk_limit_q),
		.step        (advance),
		.item        (item_s1),
		.res         (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

`ifndef SYNTH
	// A beat accepted while the input register is full must mean that register drains.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item_valid_s1) |-> advance)
		else $error("input beat accepted over a stalled input register");

	// Every processed beat shows up in the output register on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("processed beat did not reach the output register");

	// An error result never carries a request or a done flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.error != ERR_NONE)) |-> (!res_q.req_valid && !res_q.done_res))
		else $error("error result carries a request or done");

	// A result without a request leaves all request fields clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.req_valid) |->
		(res_q.req_kind == KIND_FIND && res_q.req_offset == 31'd0 &&
		 res_q.req_size == 16'd0 && res_q.req_id == 8'd0 && res_q.req_port == 16'd0))
		else $error("request fields set without a request");
`endif

endmodule
